FILE: src/hsc_pkg.sv
package hsc_pkg;

  localparam int unsigned HSC_MAX_CODE_BITS = 64;
  localparam int unsigned HSC_WORD_BITS     = 64;
  localparam int unsigned HSC_SYN_BITS      = 7;

  typedef enum logic [0:0] {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } hsc_func_e;

  typedef struct packed {
    hsc_func_e                  func;
    logic [HSC_WORD_BITS-1:0]   bits_in;
    logic [6:0]                 len_in;
  } hsc_in_t;

  typedef struct packed {
    logic [HSC_WORD_BITS-1:0]   bits_out;
    logic [6:0]                 len_out;
    logic                       corrected;
    logic                       bad_request;
    logic [31:0]                fix_count;
  } hsc_out_t;

  // Result of the datapath before the running count is attached.
  typedef struct packed {
    logic [HSC_WORD_BITS-1:0]   bits;
    logic [6:0]                 len;
    logic                       corrected;
    logic                       bad_request;
  } hsc_res_t;

  function automatic logic is_pow2(int unsigned q);
    return (q != 0) && ((q & (q - 1)) == 0);
  endfunction

  // Data bit index carried by the non-power-of-two codeword position q.
  function automatic logic [5:0] data_bit_of(int unsigned q);
    int unsigned cnt;
    cnt = 0;
    for (int unsigned b = 0; b < HSC_SYN_BITS; b++) begin
      if ((1 << b) < q) cnt++;
    end
    return 6'(q - 1 - cnt);
  endfunction

  // Positions q (1 to 64) whose bit b is set, as a mask over bit q-1.
  function automatic logic [HSC_WORD_BITS-1:0] cover_mask(logic [2:0] b);
    logic [HSC_WORD_BITS-1:0] m;
    m = '0;
    for (int unsigned q = 1; q <= HSC_WORD_BITS; q++) begin
      if (((q >> b) & 1) != 0) m[6'(q - 1)] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [HSC_WORD_BITS-1:0] low_mask(logic [7:0] n);
    logic [HSC_WORD_BITS-1:0] m;
    for (int unsigned i = 0; i < HSC_WORD_BITS; i++) begin
      m[i] = (8'(i) < n);
    end
    return m;
  endfunction

  // Fewest parity bits p with k + p + 1 <= 2^p.
  function automatic logic [3:0] parity_count(logic [6:0] k);
    logic [3:0] p;
    p = 4'd8;
    for (int b = 8; b >= 0; b--) begin
      if ((9'(k) + 9'(b) + 9'd1) <= (9'd1 << b)) p = 4'(b);
    end
    return p;
  endfunction

  // Number of power-of-two positions at or below n.
  function automatic logic [6:0] pow2_count(logic [6:0] n);
    logic [6:0] c;
    c = '0;
    for (int unsigned b = 0; b < HSC_SYN_BITS; b++) begin
      if ((7'd1 << b) <= n) c = c + 7'd1;
    end
    return c;
  endfunction

endpackage

FILE: src/hsc_stream_if.sv
interface hsc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

FILE: src/hsc_core.sv
module hsc_core import hsc_pkg::*; #(
  parameter int unsigned MaxCodeBits = HSC_MAX_CODE_BITS
) (
  input  hsc_in_t  req_i,
  output hsc_res_t res_o
);

  localparam logic [7:0] MaxBits = 8'(MaxCodeBits);

  logic [3:0]               enc_p;
  logic [7:0]               enc_n;
  logic [HSC_WORD_BITS-1:0] enc_scat;
  logic [HSC_WORD_BITS-1:0] enc_word;

  logic [6:0]               dec_n;
  logic [6:0]               dec_len;
  logic [HSC_WORD_BITS-1:0] dec_w;
  logic [HSC_WORD_BITS-1:0] dec_fix;
  logic [HSC_WORD_BITS-1:0] dec_gath;
  logic [HSC_SYN_BITS-1:0]  syn;
  logic                     syn_nz;
  logic                     syn_over;

  // Scatter data into the non-power-of-two positions, then fill in parity.
  always_comb begin
    enc_p    = parity_count(req_i.len_in);
    enc_n    = {1'b0, req_i.len_in} + {4'b0, enc_p};
    enc_scat = '0;
    for (int unsigned q = 1; q <= HSC_WORD_BITS; q++) begin
      if (!is_pow2(q)) enc_scat[6'(q - 1)] = req_i.bits_in[data_bit_of(q)];
    end
    enc_scat = enc_scat & low_mask(enc_n);
    enc_word = enc_scat;
    for (int unsigned b = 0; b < HSC_SYN_BITS; b++) begin
      enc_word[6'((1 << b) - 1)] = ^(enc_scat & cover_mask(3'(b)));
    end
  end

  // Syndrome, single-bit repair and gather of the data positions.
  always_comb begin
    dec_n = (req_i.len_in == 7'd8) ? 7'd7 : req_i.len_in;
    dec_w = req_i.bits_in & low_mask({1'b0, dec_n});
    for (int unsigned b = 0; b < HSC_SYN_BITS; b++) begin
      syn[b] = ^(dec_w & cover_mask(3'(b)));
    end
    syn_nz   = (syn != '0);
    syn_over = (syn > dec_n);
    dec_fix  = dec_w;
    if (syn_nz && !syn_over) begin
      dec_fix = dec_w ^ (64'd1 << (syn - 7'd1));
    end
    dec_gath = '0;
    for (int unsigned q = 1; q <= HSC_WORD_BITS; q++) begin
      if (!is_pow2(q)) dec_gath[data_bit_of(q)] = dec_fix[6'(q - 1)];
    end
    dec_len = dec_n - pow2_count(dec_n);
  end

  always_comb begin
    res_o = '0;
    unique case (req_i.func)
      FUNC_ENCODE: begin
        if (enc_n <= MaxBits) begin
          res_o.bits = enc_word;
          res_o.len  = enc_n[6:0];
        end else begin
          res_o.bad_request = 1'b1;
        end
      end
      FUNC_DECODE: begin
        if (({1'b0, req_i.len_in} > MaxBits) || syn_over) begin
          res_o.bad_request = 1'b1;
        end else begin
          res_o.bits      = dec_gath;
          res_o.len       = dec_len;
          res_o.corrected = syn_nz;
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: src/hamming_sec_codec.sv
// A request waits in the input register while the codec works on it, and its
// result is then offered from the result register.
// Throughput: one item per cycle unless out_o stalls; the input register and
// the result register form a two-stage pipeline, the codec pass between them.
// Reset (rst_ni low, asynchronous) empties both stages and clears the
// correction counter; payload registers are not reset.
module hamming_sec_codec import hsc_pkg::*; #(
  parameter int unsigned MaxCodeBits = HSC_MAX_CODE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsc_stream_if.sink           in_i,
  hsc_stream_if.source         out_o
);

  // Stage one holds the request as it arrived; stage two holds the finished
  // result until the downstream side takes it.
  logic        s1_valid_q;
  hsc_in_t     s1_req_q;
  logic        s2_valid_q;
  hsc_out_t    s2_data_q;
  logic [31:0] cnt_q;
  logic [31:0] cnt_d;
  hsc_res_t    res;
  logic        s2_adv;
  logic        s1_move;
  logic        in_take;

  // The result register may load whenever it is empty or being emptied, so
  // a stalled result only holds up the input once both stages are full.
  assign s2_adv     = !s2_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_adv;
  assign in_take    = in_i.valid && in_i.ready;
  assign s1_move    = s1_valid_q && s2_adv;

  hsc_core #(
    .MaxCodeBits (MaxCodeBits)
  ) u_core (
    .req_i (s1_req_q),
    .res_o (res)
  );

  // The running count of repaired words saturates at all ones. It advances
  // as an item leaves the first stage, so each result reports the count
  // including its own correction.
  always_comb begin
    cnt_d = cnt_q;
    if (s1_move && res.corrected && (cnt_q != '1)) begin
      cnt_d = cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_i.data;
    end
    if (s1_move) begin
      s2_data_q.bits_out    <= res.bits;
      s2_data_q.len_out     <= res.len;
      s2_data_q.corrected   <= res.corrected;
      s2_data_q.bad_request <= res.bad_request;
      s2_data_q.fix_count   <= cnt_d;
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.data  = s2_data_q;

`ifndef SYNTHESIS
  // The counter only ever rises or holds.
  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= $past(cnt_q))
    else $error("correction counter went backwards");

  // A repair that is not saturated bumps the counter by exactly one.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && res.corrected && (cnt_q != '1)) |=> (cnt_q == $past(cnt_q) + 32'd1))
    else $error("correction counter did not advance on a repair");

  // A repaired word is never refused, and its count cannot be zero.
  a_corr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.corrected) |->
      (!out_o.data.bad_request && (out_o.data.fix_count != '0)))
    else $error("corrected result carries refusal or zero count");
`endif

endmodule

FILE: tb/sv/tb_hamming_sec_codec.sv
module tb_hamming_sec_codec;
  import hsc_pkg::*;

  // Longest codeword the block is built for; the instance keeps the default.
  localparam int unsigned MaxBits = HSC_MAX_CODE_BITS;
  // Cycles without any transfer on either side before the run is abandoned.
  // A correct run never comes near this, even at 80 per cent idling.
  localparam int unsigned QuietLimit = 5000;
  // Cycles allowed after the last result.
  localparam int unsigned SettleCycles = 8;

  // Holds the expected results of every request that has been accepted and
  // not yet answered, together with its own copy of the correction counter.
  class hamming_checker;
    hsc_out_t    expected_words[$];
    logic [31:0] fix_total;
    int unsigned errors;
    int unsigned encodes_seen;
    int unsigned decodes_seen;
    int unsigned fixes_seen;
    int unsigned refusals_seen;

    function new();
      fix_total     = '0;
      errors        = 0;
      encodes_seen  = 0;
      decodes_seen  = 0;
      fixes_seen    = 0;
      refusals_seen = 0;
    endfunction

    static function bit parity_slot(int unsigned q);
      return $countones(q) == 1;
    endfunction

    // XOR of the positions (from 1) of every set bit in the first n bits.
    static function logic [6:0] syndrome(logic [63:0] w, int unsigned n);
      logic [6:0] s;
      s = '0;
      for (int unsigned q = 1; q <= n; q++) begin
        if (w[q-1]) s ^= 7'(q);
      end
      return s;
    endfunction

    // Encoding needs no state, so the stimulus also uses it to build codewords.
    static function hsc_out_t encode_word(logic [63:0] data, int unsigned k);
      hsc_out_t    r;
      int unsigned p;
      int unsigned n;
      int unsigned d;
      logic [6:0]  s;
      r = '0;
      p = 0;
      while (k + p + 1 > (1 << p)) p++;
      n = k + p;
      if (n > MaxBits) begin
        r.bad_request = 1'b1;
        return r;
      end
      d = 0;
      for (int unsigned q = 1; q <= n; q++) begin
        if (!parity_slot(q)) begin
          r.bits_out[q-1] = data[d];
          d++;
        end
      end
      // With the parity slots still clear, the syndrome bits are the parity.
      s = syndrome(r.bits_out, n);
      for (int unsigned b = 0; b < 7; b++) begin
        if ((1 << b) <= n && s[b]) r.bits_out[(1 << b) - 1] = 1'b1;
      end
      r.len_out = 7'(n);
      return r;
    endfunction

    function hsc_out_t predict_word(hsc_in_t req);
      hsc_out_t    r;
      int unsigned n;
      int unsigned j;
      logic [63:0] w;
      logic [6:0]  s;
      r = '0;
      if (req.func == FUNC_ENCODE) begin
        r = encode_word(req.bits_in, req.len_in);
      end else if (req.len_in > MaxBits) begin
        r.bad_request = 1'b1;
      end else begin
        // An eight-bit word carries a pad bit on top of a 7-bit codeword.
        n = (req.len_in == 7'd8) ? 7 : req.len_in;
        w = '0;
        for (int unsigned i = 0; i < n; i++) w[i] = req.bits_in[i];
        s = syndrome(w, n);
        if (s > n) begin
          r.bad_request = 1'b1;
        end else begin
          if (s != 0) begin
            w[s-1] = ~w[s-1];
            r.corrected = 1'b1;
            if (fix_total != 32'hFFFF_FFFF) fix_total++;
          end
          j = 0;
          for (int unsigned q = 1; q <= n; q++) begin
            if (!parity_slot(q)) begin
              r.bits_out[j] = w[q-1];
              j++;
            end
          end
          r.len_out = 7'(j);
        end
      end
      r.fix_count = fix_total;
      return r;
    endfunction

    function void note_request(hsc_in_t req);
      hsc_out_t r;
      r = predict_word(req);
      if (req.func == FUNC_ENCODE) encodes_seen++;
      else decodes_seen++;
      if (r.corrected) fixes_seen++;
      if (r.bad_request) refusals_seen++;
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hsc_out_t got);
      hsc_out_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result %h arrived with no request waiting", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("bits_out", want.bits_out, got.bits_out);
      compare_field("len_out", 64'(want.len_out), 64'(got.len_out));
      compare_field("corrected", 64'(want.corrected), 64'(got.corrected));
      compare_field("bad_request", 64'(want.bad_request), 64'(got.bad_request));
      compare_field("fix_count", 64'(want.fix_count), 64'(got.fix_count));
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsc_stream_if #(.payload_t(hsc_in_t))  req_if ();
  hsc_stream_if #(.payload_t(hsc_out_t)) rsp_if ();

  hamming_sec_codec dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  hamming_checker checker_h = new();

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a transfer. The stimulus changes them from phase to phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  // The receiver decides afresh on every cycle whether it will take a result.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both sides are sampled at the rising edge, where all drivers have settled
  // and every change caused by the edge is still pending. Each accepted request
  // is turned into an expectation at once, so results come back in the order
  // in which their requests were taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) checker_h.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) checker_h.check_result(rsp_if.data);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
    $display("tb_hamming_sec_codec NOT OK");
    $finish;
  end

  function automatic hsc_in_t make_request(hsc_func_e f, logic [63:0] b, int unsigned l);
    hsc_in_t r;
    r.func    = f;
    r.bits_in = b;
    r.len_in  = 7'(l);
    return r;
  endfunction

  // Offers one request and returns at the edge where it is transferred. The
  // valid line stays high into the next call, so back-to-back requests need
  // no gap; when the sender idles, valid is lowered for whole cycles.
  task automatic send_request(hsc_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // The sender holds back until every outstanding result has come home. The
  // first edge is always waited for, so valid never falls and rises together.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (checker_h.pending() != 0) @(posedge clk_i);
  endtask

  // Random traffic. Most of it is an encode followed by a decode of the very
  // codeword it yields, clean or with one or two flipped bits, so that real
  // corrections happen; junk above the word length checks that unused bits
  // are ignored. The rest is random decodes, random encodes and requests of
  // any length the field can hold, oversized ones included.
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    int unsigned dec_len;
    logic [63:0] data;
    logic [63:0] word;
    hsc_out_t    cw;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      data = {$urandom, $urandom};
      if (pick < 75) begin
        // Four data bits give a 7-bit codeword, which is also tried padded.
        k = ($urandom_range(5) == 0) ? 4 : $urandom_range(57);
        send_request(make_request(FUNC_ENCODE, data, k));
        cw = hamming_checker::encode_word(data, k);
        n = cw.len_out;
        word = cw.bits_out | ({$urandom, $urandom} & ~((64'd1 << n) - 64'd1));
        dec_len = n;
        case ($urandom_range(5))
          0, 1: ;
          2, 3: begin
            if (n > 0) word[$urandom_range(n - 1)] ^= 1'b1;
          end
          4: begin
            // Two flips: unless they cancel, either miscorrected or refused, never fixed.
            if (n > 0) word[$urandom_range(n - 1)] ^= 1'b1;
            if (n > 0) word[$urandom_range(n - 1)] ^= 1'b1;
          end
          default: begin
            if (n == 7) dec_len = 8;
            else if (n > 0) word[$urandom_range(n - 1)] ^= 1'b1;
          end
        endcase
        send_request(make_request(FUNC_DECODE, word, dec_len));
        sent += 2;
      end else if (pick < 90) begin
        send_request(make_request(FUNC_DECODE, data, $urandom_range(64)));
        sent++;
      end else if (pick < 95) begin
        send_request(make_request(FUNC_ENCODE, data, $urandom_range(64)));
        sent++;
      end else begin
        send_request(make_request(hsc_func_e'($urandom_range(1)), data,
                                  $urandom_range(127)));
        sent++;
      end
    end
  endtask

  initial begin
    hsc_out_t    cw4;
    hsc_out_t    cw57;
    int          idle_by_phase [4];
    int          stall_by_phase [4];

    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;

    // Phases: free running, a slow sender, a slow receiver, then both
    // hesitating a little.
    idle_by_phase  = '{0, 80, 0, 11};
    stall_by_phase = '{0, 0, 80, 11};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    cw4  = hamming_checker::encode_word(64'hF, 4);
    cw57 = hamming_checker::encode_word({$urandom, $urandom}, 57);

    // Directed part, with no idling on either side.
    // Encode: empty word, smallest words, the boundaries where one more
    // parity bit is needed, the largest word that fits and the first that
    // does not, up to the largest length the field can hold.
    send_request(make_request(FUNC_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    send_request(make_request(FUNC_ENCODE, 64'h1, 1));
    send_request(make_request(FUNC_ENCODE, 64'hF, 4));
    send_request(make_request(FUNC_ENCODE, 64'h7FF, 11));
    send_request(make_request(FUNC_ENCODE, 64'h2AAA_AAAA, 26));
    send_request(make_request(FUNC_ENCODE, 64'h5555_5555, 27));
    send_request(make_request(FUNC_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 57));
    send_request(make_request(FUNC_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA, 57));
    send_request(make_request(FUNC_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 58));
    send_request(make_request(FUNC_ENCODE, 64'h0123_4567_89AB_CDEF, 64));
    send_request(make_request(FUNC_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 127));
    // Decode: clean and corrupted short codewords, the padded eight-bit
    // form with and without an error, an empty word, a single bit that names
    // itself, syndromes that point past the word, power-of-two lengths, the
    // longest words and oversized ones.
    send_request(make_request(FUNC_DECODE, cw4.bits_out, 7));
    send_request(make_request(FUNC_DECODE, cw4.bits_out ^ 64'h10, 7));
    send_request(make_request(FUNC_DECODE, cw4.bits_out | 64'h80, 8));
    send_request(make_request(FUNC_DECODE, (cw4.bits_out ^ 64'h4) | 64'hF00, 8));
    send_request(make_request(FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    send_request(make_request(FUNC_DECODE, 64'h1, 1));
    send_request(make_request(FUNC_DECODE, 64'hC, 5));
    send_request(make_request(FUNC_DECODE, 64'h3, 2));
    send_request(make_request(FUNC_DECODE, {$urandom, $urandom}, 16));
    send_request(make_request(FUNC_DECODE, {$urandom, $urandom}, 32));
    send_request(make_request(FUNC_DECODE, cw57.bits_out ^ (64'd1 << 62), 63));
    send_request(make_request(FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64));
    send_request(make_request(FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 65));
    send_request(make_request(FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 127));

    for (int ph = 0; ph < 4; ph++) begin
      // Every phase starts from an empty pipeline, which also makes the
      // sender wait for all outstanding results before it carries on.
      drain_results();
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      run_random(100);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d encodes and %0d decodes, with %0d single-bit corrections",
             checker_h.encodes_seen, checker_h.decodes_seen, checker_h.fixes_seen);
    $display("and %0d refused requests, under four idling patterns.",
             checker_h.refusals_seen);
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("tb_hamming_sec_codec OK");
    end else begin
      $display("tb_hamming_sec_codec NOT OK");
    end
    $finish;
  end

endmodule
